// ----- design/pelc_pkg.sv -----
// Shared constants and types for the performance event latency counters.
package pelc_pkg;

  localparam int unsigned NUM_STAGES  = 4;
  localparam int unsigned NUM_CLASSES = 6;
  localparam int unsigned SEL_W       = 5;
  localparam int unsigned OUT_W       = 64;

  // Counter select codes; each group occupies consecutive codes.
  localparam int unsigned CNT_CYCLES    = 0;
  localparam int unsigned CNT_INSTS     = 1;
  localparam int unsigned CNT_STAGE_EVT = 2;
  localparam int unsigned CNT_STAGE_CYC = 6;
  localparam int unsigned CNT_CLASS_EVT = 10;
  localparam int unsigned CNT_CLASS_CYC = 16;
  localparam int unsigned CNT_HIT_EVT   = 22;
  localparam int unsigned CNT_HIT_CYC   = 23;
  localparam int unsigned CNT_MISS_EVT  = 24;
  localparam int unsigned CNT_MISS_CYC  = 25;
  localparam int unsigned NUM_CNT       = 26;

  // Event bits of one tick.
  typedef struct packed {
    logic                   inst_start;
    logic                   inst_end;
    logic [NUM_STAGES-1:0]  stage_fire;
    logic [NUM_STAGES-1:0]  stage_done;
    logic                   class_valid;
    logic [NUM_CLASSES-1:0] inst_class;
    logic                   icache_lookup;
    logic                   icache_hit;
    logic                   icache_miss;
  } ev_t;

endpackage

// ----- design/pelc_if.sv -----
// Request and response channel interfaces.
interface pelc_req_if;
  logic                            valid;
  logic                            ready;
  logic                            inst_start;
  logic                            inst_end;
  logic [pelc_pkg::NUM_STAGES-1:0]  stage_fire;
  logic [pelc_pkg::NUM_STAGES-1:0]  stage_done;
  logic                            class_valid;
  logic [pelc_pkg::NUM_CLASSES-1:0] inst_class;
  logic                            icache_lookup;
  logic                            icache_hit;
  logic                            icache_miss;
  logic [pelc_pkg::SEL_W-1:0]       counter_select;

  modport source (output valid, inst_start, inst_end, stage_fire, stage_done, class_valid,
                  inst_class, icache_lookup, icache_hit, icache_miss, counter_select,
                  input ready);
  modport sink (input valid, inst_start, inst_end, stage_fire, stage_done, class_valid,
                inst_class, icache_lookup, icache_hit, icache_miss, counter_select,
                output ready);
endinterface

interface pelc_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [pelc_pkg::OUT_W-1:0] counter_value;

  modport source (output valid, counter_value, input ready);
  modport sink (input valid, counter_value, output ready);
endinterface

// ----- design/pelc_lat_slot.sv -----
// One latency tracker: pending flag and running elapsed-tick count.
module pelc_lat_slot #(
  parameter int unsigned W = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         step_i,
  input  logic         open_i,
  input  logic         close_i,
  output logic         closing_o,
  output logic [W-1:0] lat_o
);

  logic         pending_q;
  logic [W-1:0] elapsed_q;
  logic         pend_eff;

  // elapsed_q is the latency a close would see on the next tick.
  assign pend_eff  = open_i | pending_q;
  assign closing_o = close_i & pend_eff;
  assign lat_o     = open_i ? '0 : elapsed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 1'b0;
      elapsed_q <= '0;
    end else if (step_i) begin
      pending_q <= pend_eff & ~close_i;
      if (open_i) begin
        elapsed_q <= W'(1);
      end else if (pending_q) begin
        elapsed_q <= elapsed_q + W'(1);
      end
    end
  end

endmodule

// ----- design/pelc_counters.sv -----
// Counter bank: event counts and latency sums, updated once per tick.
module pelc_counters #(
  parameter int unsigned W = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  pelc_pkg::ev_t       ev_i,
  output logic [W-1:0]        cnt_nxt_o [pelc_pkg::NUM_CNT]
);

  localparam int unsigned CLASS_BASE = pelc_pkg::NUM_STAGES;
  localparam int unsigned CACHE_SLOT = pelc_pkg::NUM_STAGES + pelc_pkg::NUM_CLASSES;
  localparam int unsigned NUM_SLOTS  = CACHE_SLOT + 1;

  logic [W-1:0] cnt_q [pelc_pkg::NUM_CNT];
  logic [W-1:0] cnt_d [pelc_pkg::NUM_CNT];
  logic         open   [NUM_SLOTS];
  logic         close  [NUM_SLOTS];
  logic         closing[NUM_SLOTS];
  logic [W-1:0] lat    [NUM_SLOTS];

  for (genvar s = 0; s < pelc_pkg::NUM_STAGES; s++) begin : g_stage
    assign open[s]  = ev_i.stage_fire[s];
    assign close[s] = ev_i.stage_done[s];
  end
  for (genvar c = 0; c < pelc_pkg::NUM_CLASSES; c++) begin : g_class
    assign open[CLASS_BASE + c]  = ev_i.class_valid & ev_i.inst_class[c];
    assign close[CLASS_BASE + c] = ev_i.inst_end;
  end
  // Hit wins over miss in the same tick; both close the single lookup.
  assign open[CACHE_SLOT]  = ev_i.icache_lookup;
  assign close[CACHE_SLOT] = ev_i.icache_hit | ev_i.icache_miss;

  for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_slot
    pelc_lat_slot #(.W(W)) u_slot (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .step_i   (step_i),
      .open_i   (open[k]),
      .close_i  (close[k]),
      .closing_o(closing[k]),
      .lat_o    (lat[k])
    );
  end

  always_comb begin
    cnt_d = cnt_q;
    cnt_d[pelc_pkg::CNT_CYCLES] = cnt_q[pelc_pkg::CNT_CYCLES] + W'(1);
    if (ev_i.inst_start) begin
      cnt_d[pelc_pkg::CNT_INSTS] = cnt_q[pelc_pkg::CNT_INSTS] + W'(1);
    end
    for (int i = 0; i < pelc_pkg::NUM_STAGES; i++) begin
      if (open[i]) begin
        cnt_d[pelc_pkg::CNT_STAGE_EVT + i] = cnt_q[pelc_pkg::CNT_STAGE_EVT + i] + W'(1);
      end
      if (closing[i]) begin
        cnt_d[pelc_pkg::CNT_STAGE_CYC + i] = cnt_q[pelc_pkg::CNT_STAGE_CYC + i] + lat[i];
      end
    end
    for (int i = 0; i < pelc_pkg::NUM_CLASSES; i++) begin
      if (open[CLASS_BASE + i]) begin
        cnt_d[pelc_pkg::CNT_CLASS_EVT + i] = cnt_q[pelc_pkg::CNT_CLASS_EVT + i] + W'(1);
      end
      if (closing[CLASS_BASE + i]) begin
        cnt_d[pelc_pkg::CNT_CLASS_CYC + i] =
          cnt_q[pelc_pkg::CNT_CLASS_CYC + i] + lat[CLASS_BASE + i];
      end
    end
    if (closing[CACHE_SLOT]) begin
      if (ev_i.icache_hit) begin
        cnt_d[pelc_pkg::CNT_HIT_EVT] = cnt_q[pelc_pkg::CNT_HIT_EVT] + W'(1);
        cnt_d[pelc_pkg::CNT_HIT_CYC] = cnt_q[pelc_pkg::CNT_HIT_CYC] + lat[CACHE_SLOT];
      end else begin
        cnt_d[pelc_pkg::CNT_MISS_EVT] = cnt_q[pelc_pkg::CNT_MISS_EVT] + W'(1);
        cnt_d[pelc_pkg::CNT_MISS_CYC] = cnt_q[pelc_pkg::CNT_MISS_CYC] + lat[CACHE_SLOT];
      end
    end
  end

  assign cnt_nxt_o = cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < pelc_pkg::NUM_CNT; i++) begin
        cnt_q[i] <= '0;
      end
    end else if (step_i) begin
      cnt_q <= cnt_d;
    end
  end

endmodule

// ----- design/perf_event_latency_counters.sv -----
// Top level of the performance event latency counters.
//
// Each request carries the event bits of one processor tick plus a counter
// select. The request lands in an input register; when it moves on, the
// counter bank applies the whole tick in one pass (cycle count, instruction
// count, stage fire/done, class stamp/close on instruction end, cache
// lookup/hit/miss) and the selected counter's new value is captured in the
// output register. Throughput is one request per clock: the input register
// refills in the same cycle it drains, and it drains whenever the output
// register is empty or being taken. The response is registered: a request
// passes through the input register and then the output register, which
// drives the response. Latencies are kept as running
// elapsed-tick counts per pending slot, so each sum update is a single add.
// Counters are COUNTER_WIDTH bits wide, wrap at 2^COUNTER_WIDTH, and are
// zero-extended onto the 64-bit response; select codes 26 to 31 read as zero.
module perf_event_latency_counters #(
  parameter int unsigned COUNTER_WIDTH = 64
) (
  input logic       clk_i,
  input logic       rst_ni,
  pelc_req_if.sink  req,
  pelc_rsp_if.source rsp
);

  logic                         in_vld_q;
  pelc_pkg::ev_t                ev_q;
  logic [pelc_pkg::SEL_W-1:0]   sel_q;
  logic                         out_vld_q;
  logic [pelc_pkg::OUT_W-1:0]   value_q;
  logic                         advance;
  logic [COUNTER_WIDTH-1:0]     cnt_nxt [pelc_pkg::NUM_CNT];
  logic [pelc_pkg::OUT_W-1:0]   value_d;

  // Tick moves from input register to output register.
  assign advance   = in_vld_q & (~out_vld_q | rsp.ready);
  assign req.ready = ~in_vld_q | advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (req.ready) begin
      in_vld_q <= req.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req.valid && req.ready) begin
      ev_q.inst_start    <= req.inst_start;
      ev_q.inst_end      <= req.inst_end;
      ev_q.stage_fire    <= req.stage_fire;
      ev_q.stage_done    <= req.stage_done;
      ev_q.class_valid   <= req.class_valid;
      ev_q.inst_class    <= req.inst_class;
      ev_q.icache_lookup <= req.icache_lookup;
      ev_q.icache_hit    <= req.icache_hit;
      ev_q.icache_miss   <= req.icache_miss;
      sel_q              <= req.counter_select;
    end
  end

  pelc_counters #(.W(COUNTER_WIDTH)) u_counters (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .ev_i     (ev_q),
    .cnt_nxt_o(cnt_nxt)
  );

  // Read the selected counter as it stands after this tick.
  always_comb begin
    if (sel_q < pelc_pkg::SEL_W'(pelc_pkg::NUM_CNT)) begin
      value_d = pelc_pkg::OUT_W'(cnt_nxt[sel_q]);
    end else begin
      value_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (rsp.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      value_q <= value_d;
    end
  end

  assign rsp.valid         = out_vld_q;
  assign rsp.counter_value = value_q;

endmodule
